// File: rtl/fir_pkg.sv
// shared constants and types of the loadable-tap fir filter
// no dependencies; imported by the interfaces and all rtl modules
package fir_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  // q1.15 coefficients: fraction bits dropped from the sum
  localparam int unsigned FRAC_W   = 15;

  // default tap count
  localparam int unsigned TAPS_DEF = 100;

  // request kinds
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // saturation limits
  localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // controls shared by every cell of the ring
  typedef struct packed {
    logic shift_en;  // push a new sample into the delay chain
    logic rot_en;    // rotate sample and coefficient one cell toward the head
  } cell_ctrl_t;

  // controls of the multiply-accumulate unit
  typedef struct packed {
    logic clear;     // start a new sum
    logic mul_en;    // multiply the head cell's pair this cycle
  } mac_ctrl_t;

endpackage

// File: rtl/fir_if.sv
// request and result channels of the fir filter
// depends on fir_pkg for field widths
interface fir_in_if;
  import fir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic        [IDX_W-1:0]    coef_index;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (output valid, action, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, action, sample_in, coef_index, coef_value, output ready);
endinterface

interface fir_out_if;
  import fir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink   (input valid, filtered, saturated, output ready);
endinterface

// File: rtl/fir_cell.sv
// one cell of the tap ring: holds one delay sample and one coefficient
// depends on fir_pkg
module fir_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fir_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                load_i,
  input  logic signed [fir_pkg::COEF_W-1:0]   load_coef_i,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] shift_sample_i,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] rot_sample_i,
  input  logic signed [fir_pkg::COEF_W-1:0]   rot_coef_i,
  output logic signed [fir_pkg::SAMPLE_W-1:0] sample_o,
  output logic signed [fir_pkg::COEF_W-1:0]   coef_o
);
  import fir_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic signed [COEF_W-1:0]   coef_q, coef_d;

  // rotate during a sum, shift on a push, write on a matching load
  always_comb begin
    sample_d = sample_q;
    coef_d   = coef_q;
    if (ctrl_i.rot_en) begin
      sample_d = rot_sample_i;
      coef_d   = rot_coef_i;
    end else if (ctrl_i.shift_en) begin
      sample_d = shift_sample_i;
    end else if (load_i) begin
      coef_d = load_coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      coef_q   <= '0;
    end else begin
      sample_q <= sample_d;
      coef_q   <= coef_d;
    end
  end

  assign sample_o = sample_q;
  assign coef_o   = coef_q;

endmodule

// File: rtl/fir_mac.sv
// multiply-accumulate unit at the head of the ring, with truncation and clipping
// depends on fir_pkg
module fir_mac #(
  parameter int unsigned Taps = fir_pkg::TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fir_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [fir_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [fir_pkg::SAMPLE_W-1:0] filtered_o,
  output logic                                saturated_o
);
  import fir_pkg::*;

  localparam int unsigned AccW = PROD_W + $clog2(Taps);
  localparam int unsigned QW   = AccW - FRAC_W;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic        [QW-1:0]     quot;
  logic                     round_up;
  logic        [QW-SAMPLE_W:0] top_bits;

  // product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= coef_i * sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  // accumulator
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(AccW-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // divide by 2^15 truncating toward zero: negative sums with a fraction move up one
  assign round_up = acc_q[AccW-1] & (|acc_q[FRAC_W-1:0]);
  assign quot     = acc_q[AccW-1:FRAC_W] + {{(QW-1){1'b0}}, round_up};

  // clip when the bits above the sample's sign differ from it
  assign top_bits    = quot[QW-1:SAMPLE_W-1];
  assign saturated_o = !((&top_bits) || !(|top_bits));
  assign filtered_o  = saturated_o ? (quot[QW-1] ? SAT_MIN : SAT_MAX)
                                   : quot[SAMPLE_W-1:0];

endmodule

// File: rtl/fir_filter_loadable_taps_top.sv
// top level of the loadable-tap fir filter: control, ring of tap cells, mac unit
// depends on fir_pkg, fir_if, fir_cell and fir_mac
//
// usage
//   in_i carries requests: action 1 writes coef_value into tap coef_index
//   (an index of TAPS or more is dropped), action 0 pushes sample_in.
//   out_o carries one result per pushed sample: the sum of TAPS products,
//   divided by 2^15 toward zero and clipped to 16 bits, with a clip flag.
//   a load gives no result and leaves the block ready again.
//   a push shifts the sample into the ring, then the ring rotates one full
//   turn past the single 16x16 multiplier at its head; the drain state
//   adds the last product from the product register, and the finish state
//   clips the sum into the output register. the next request is taken only
//   after that, since the one shared multiplier serves every tap in turn.
//   a result held in the output register does not block the next request;
//   only a second finished result waits until the receiver takes the first.
//   reset clears the delay line, all coefficients and the output valid flag.
module fir_filter_loadable_taps_top #(
  parameter int unsigned TAPS = fir_pkg::TAPS_DEF
) (
  input logic  clk_i,
  input logic  rst_ni,
  fir_in_if.sink    in_i,
  fir_out_if.source out_o
);
  import fir_pkg::*;

  localparam int unsigned CntW = $clog2(TAPS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic in_acc, push_acc, load_acc, out_free;
  cell_ctrl_t cell_ctrl;
  mac_ctrl_t  mac_ctrl;

  logic signed [SAMPLE_W-1:0] cell_sample [TAPS];
  logic signed [COEF_W-1:0]   cell_coef   [TAPS];
  logic        [TAPS-1:0]     cell_load;

  logic signed [SAMPLE_W-1:0] mac_filtered;
  logic                       mac_saturated;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic                       saturated_q;

  // request handshake
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign push_acc   = in_acc && (in_i.action == ACT_PUSH);
  assign load_acc   = in_acc && (in_i.action == ACT_LOAD);
  assign out_free   = !out_valid_q || out_o.ready;

  // sequencer
  always_comb begin
    state_d            = state_q;
    cnt_d              = cnt_q;
    cell_ctrl.shift_en = 1'b0;
    cell_ctrl.rot_en   = 1'b0;
    mac_ctrl.clear     = 1'b0;
    mac_ctrl.mul_en    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (push_acc) begin
          cell_ctrl.shift_en = 1'b1;
          mac_ctrl.clear     = 1'b1;
          cnt_d              = '0;
          state_d            = ST_RUN;
        end
      end
      ST_RUN: begin
        cell_ctrl.rot_en = 1'b1;
        mac_ctrl.mul_en  = 1'b1;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == CntW'(TAPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // ring of tap cells: shift moves toward higher index, rotate toward cell 0
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    assign cell_load[k] = load_acc && (32'(in_i.coef_index) == 32'(k));

    fir_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .load_i        (cell_load[k]),
      .load_coef_i   (in_i.coef_value),
      .shift_sample_i((k == 0) ? in_i.sample_in : cell_sample[(k + TAPS - 1) % TAPS]),
      .rot_sample_i  (cell_sample[(k + 1) % TAPS]),
      .rot_coef_i    (cell_coef[(k + 1) % TAPS]),
      .sample_o      (cell_sample[k]),
      .coef_o        (cell_coef[k])
    );
  end

  // multiply-accumulate at the head cell
  fir_mac #(
    .Taps(TAPS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .coef_i     (cell_coef[0]),
    .sample_i   (cell_sample[0]),
    .filtered_o (mac_filtered),
    .saturated_o(mac_saturated)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_FINISH) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && out_free) begin
      filtered_q  <= mac_filtered;
      saturated_q <= mac_saturated;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.filtered  = filtered_q;
  assign out_o.saturated = saturated_q;

endmodule

// File: rtl/fir_chk.sv
// port-level checks of the fir filter top, attached by bind
// depends on fir_pkg and fir_filter_loadable_taps_top
module fir_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                in_action_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [fir_pkg::SAMPLE_W-1:0] out_filtered_i,
  input logic                                out_saturated_i
);
  import fir_pkg::*;

  // a push keeps the block busy for the following cycle
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i == ACT_PUSH)) |=> !in_ready_i)
    else $error("request taken right after a push");

  // a coefficient load leaves the block ready again
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i == ACT_LOAD)) |=> in_ready_i)
    else $error("block busy after a load");

  // a clipped result sits at one of the limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_saturated_i) |->
      ((out_filtered_i == SAT_MAX) || (out_filtered_i == SAT_MIN)))
    else $error("clip flag without a limit value");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_filtered_i) && $stable(out_saturated_i)))
    else $error("stalled result changed");

endmodule

bind fir_filter_loadable_taps_top fir_chk u_fir_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_action_i    (in_i.action),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_filtered_i (out_o.filtered),
  .out_saturated_i(out_o.saturated)
);
